### sv/orl_pkg.sv
// Shared constants, types and helper functions for the overwriting ring LIFO.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package orl_pkg;

  // Store geometry.
  localparam int DEPTH        = 32;
  localparam int RECORD_WIDTH = 64;
  localparam int PTR_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int RESET_CAP    = (32 > DEPTH) ? DEPTH : 32;

  // Port field widths.
  localparam int REQ_W    = 2;
  localparam int REC_W    = 64;
  localparam int AMT_W    = 6;
  localparam int CAP_W    = 6;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 6;
  localparam int WIDE_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [WIDE_W-1:0]       wide_t;
  typedef logic [RECORD_WIDTH-1:0] rec_t;
  typedef logic [REC_W-1:0]        rec_port_t;
  typedef logic [COUNT_W-1:0]      count_port_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_DROP = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_ZERO_AMT = 2'd2
  } status_t;

  // What the output register is loaded with.
  typedef enum logic {
    SEL_NONE   = 1'b0,
    SEL_RECORD = 1'b1
  } res_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic     load_cap;
    logic     do_push;
    logic     do_pop;
    logic     do_drop;
    logic     peek_start;
    logic     peek_next;
    logic     out_load;
    res_sel_t out_sel;
    status_t  out_status;
    logic     out_last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;
    logic amt_zero;
    logic remain_one;
  } stat_t;

  // A written capacity of zero acts as one; anything above DEPTH acts as DEPTH.
  function automatic cnt_t cap_clamp(logic [CAP_W-1:0] v);
    cnt_t r;
    if (v == '0) begin
      r = cnt_t'(1);
    end else if (wide_t'(v) > wide_t'(DEPTH)) begin
      r = cnt_t'(DEPTH);
    end else begin
      r = cnt_t'(v);
    end
    return r;
  endfunction

  // Amounts above DEPTH saturate to DEPTH.
  function automatic cnt_t amt_clamp(logic [AMT_W-1:0] v);
    cnt_t r;
    if (wide_t'(v) > wide_t'(DEPTH)) begin
      r = cnt_t'(DEPTH);
    end else begin
      r = cnt_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/orl_if.sv
// Valid/ready channel interfaces for requests, results and the capacity register.
// Depends on orl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface orl_req_if;
  logic                          valid;
  logic                          ready;
  logic [orl_pkg::REQ_W-1:0]     req_type;
  logic [orl_pkg::REC_W-1:0]     record_in;
  logic [orl_pkg::AMT_W-1:0]     amount;

  modport source (output valid, output req_type, output record_in, output amount,
                  input ready);
  modport sink   (input valid, input req_type, input record_in, input amount,
                  output ready);
endinterface

interface orl_res_if;
  logic                          valid;
  logic                          ready;
  logic [orl_pkg::REC_W-1:0]     record_out;
  logic                          record_valid;
  logic [orl_pkg::STAT_W-1:0]    status;
  logic [orl_pkg::COUNT_W-1:0]   stored_count;
  logic                          last_of_run;

  modport source (output valid, output record_out, output record_valid, output status,
                  output stored_count, output last_of_run, input ready);
  modport sink   (input valid, input record_out, input record_valid, input status,
                  input stored_count, input last_of_run, output ready);
endinterface

interface orl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [orl_pkg::CAP_W-1:0]     capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

`default_nettype wire

### sv/orl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module orl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/orl_ctrl.sv
// Sequencing controller: accepts requests, issues datapath commands, owns result valid.
// Depends on orl_pkg for the command and status structs and the request codes.
`timescale 1ns / 1ps
`default_nettype none

module orl_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  input  wire logic [orl_pkg::REQ_W-1:0] req_type,
  output logic                           req_ready,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  input  wire orl_pkg::stat_t            st,
  output orl_pkg::cmd_t                  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   req_acc;

  assign out_free  = !res_valid || res_ready;
  assign cfg_ready = (state == S_IDLE);
  assign req_ready = (state == S_IDLE) && out_free && !cfg_valid;
  assign req_acc   = req_valid && req_ready;

  always_comb begin
    cmd            = '0;
    cmd.out_sel    = orl_pkg::SEL_NONE;
    cmd.out_status = orl_pkg::STAT_OK;
    state_next     = state;
    cmd.load_cap   = cfg_valid && cfg_ready;

    unique case (state)
      S_IDLE: begin
        if (req_acc) begin
          unique case (orl_pkg::req_t'(req_type))
            orl_pkg::REQ_PUSH: begin
              cmd.do_push  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
            orl_pkg::REQ_POP: begin
              if (st.empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = orl_pkg::STAT_EMPTY;
                cmd.out_last   = 1'b1;
              end else begin
                cmd.do_pop = 1'b1;
                state_next = S_WAIT;
              end
            end
            orl_pkg::REQ_PEEK: begin
              if (st.amt_zero) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = orl_pkg::STAT_ZERO_AMT;
                cmd.out_last   = 1'b1;
              end else if (st.empty) begin
                cmd.out_load = 1'b1;
                cmd.out_last = 1'b1;
              end else begin
                cmd.peek_start = 1'b1;
                state_next     = S_WAIT;
              end
            end
            orl_pkg::REQ_DROP: begin
              cmd.do_drop  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
          endcase
        end
      end
      // The RAM read issued last cycle lands in its output register now.
      S_WAIT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = orl_pkg::SEL_RECORD;
          cmd.out_last = st.remain_one;
          if (st.remain_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.peek_next = 1'b1;
            state_next    = S_WAIT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/orl_dp.sv
// Datapath: ring pointers, record count, capacity register, record RAM and result register.
// Depends on orl_pkg and orl_ram.
`timescale 1ns / 1ps
`default_nettype none

module orl_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire orl_pkg::cmd_t              cmd,
  input  wire logic [orl_pkg::REC_W-1:0]  record_in,
  input  wire logic [orl_pkg::AMT_W-1:0]  amount,
  input  wire logic [orl_pkg::CAP_W-1:0]  cap_wdata,
  output orl_pkg::stat_t                  st,
  output logic [orl_pkg::REC_W-1:0]       record_out,
  output logic                            record_valid,
  output logic [orl_pkg::STAT_W-1:0]      status,
  output logic [orl_pkg::COUNT_W-1:0]     stored_count,
  output logic                            last_of_run
);

  orl_pkg::cnt_t capacity;
  orl_pkg::ptr_t top;
  orl_pkg::cnt_t held;
  orl_pkg::ptr_t walk;
  orl_pkg::cnt_t remain;

  orl_pkg::cnt_t capacity_next;
  orl_pkg::ptr_t top_next;
  orl_pkg::cnt_t held_next;
  orl_pkg::ptr_t walk_next;
  orl_pkg::cnt_t remain_next;

  orl_pkg::cnt_t amt_c;
  orl_pkg::ptr_t top_back;
  orl_pkg::ptr_t top_fwd;
  orl_pkg::ptr_t walk_back;
  orl_pkg::cnt_t top_ext;
  orl_pkg::cnt_t drop_n;
  orl_pkg::ptr_t drop_top;
  orl_pkg::cnt_t peek_n;
  orl_pkg::ptr_t raddr;
  logic          re;
  orl_pkg::rec_t rdata;

  assign st.empty      = (held == '0);
  assign st.amt_zero   = (amount == '0);
  assign st.remain_one = (remain == orl_pkg::cnt_t'(1));

  always_comb begin
    amt_c     = orl_pkg::amt_clamp(amount);
    top_ext   = orl_pkg::cnt_t'(top);
    top_back  = (top == '0) ? orl_pkg::ptr_t'(capacity - 1'b1) : top - 1'b1;
    walk_back = (walk == '0) ? orl_pkg::ptr_t'(capacity - 1'b1) : walk - 1'b1;
    top_fwd   = (top_ext + 1'b1 == capacity) ? '0 : top + 1'b1;
    drop_n    = (amt_c < held) ? amt_c : held;
    // The true result stays below the capacity, so wrapping in the narrow sum is harmless.
    drop_top  = (top_ext >= drop_n) ? orl_pkg::ptr_t'(top_ext - drop_n)
                                    : orl_pkg::ptr_t'(top_ext + capacity - drop_n);
    peek_n    = (held < amt_c) ? held : amt_c;

    capacity_next = capacity;
    top_next      = top;
    held_next     = held;
    walk_next     = walk;
    remain_next   = remain;
    priority if (cmd.load_cap) begin
      capacity_next = orl_pkg::cap_clamp(cap_wdata);
      top_next      = '0;
      held_next     = '0;
    end else if (cmd.do_push) begin
      top_next = top_fwd;
      if (held < capacity) begin
        held_next = held + 1'b1;
      end
    end else if (cmd.do_pop) begin
      top_next    = top_back;
      held_next   = held - 1'b1;
      remain_next = orl_pkg::cnt_t'(1);
    end else if (cmd.do_drop) begin
      top_next  = drop_top;
      held_next = held - drop_n;
    end else if (cmd.peek_start) begin
      walk_next   = top_back;
      remain_next = peek_n;
    end else if (cmd.peek_next) begin
      walk_next   = walk_back;
      remain_next = remain - 1'b1;
    end

    re    = cmd.do_pop || cmd.peek_start || cmd.peek_next;
    raddr = cmd.peek_next ? walk_back : top_back;
  end

  orl_ram #(
    .WIDTH (orl_pkg::RECORD_WIDTH),
    .DEPTH (orl_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.do_push),
    .waddr (top),
    .wdata (record_in[orl_pkg::RECORD_WIDTH-1:0]),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= orl_pkg::cnt_t'(orl_pkg::RESET_CAP);
      top      <= '0;
      held     <= '0;
      remain   <= '0;
    end else begin
      capacity <= capacity_next;
      top      <= top_next;
      held     <= held_next;
      remain   <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    walk <= walk_next;
    if (cmd.out_load) begin
      stored_count <= orl_pkg::count_port_t'(held_next);
      last_of_run  <= cmd.out_last;
      if (cmd.out_sel == orl_pkg::SEL_RECORD) begin
        record_out   <= orl_pkg::rec_port_t'(rdata);
        record_valid <= 1'b1;
        status       <= orl_pkg::STAT_OK;
      end else begin
        record_out   <= '0;
        record_valid <= 1'b0;
        status       <= cmd.out_status;
      end
    end
  end

endmodule

`default_nettype wire

### sv/overwriting_ring_lifo.sv
// Top level of the overwriting ring LIFO: joins controller and datapath to the channels.
// Depends on orl_pkg, the channel interfaces, orl_ctrl, orl_dp and orl_ram.
//
//   Channel  Direction  Beat carries
//   req      in         req_type, record_in, amount
//   res      out        record_out, record_valid, status, stored_count, last_of_run
//   cfg      in         capacity_in_use
//
// Push, drop and every error or empty result load the result register on acceptance.
// Pop goes through accept, the registered RAM read, then the result load.
// Peek emits each record through a registered RAM read and then a result load.
// Reset clears pointer and count and sets the capacity to 32; records are not cleared.
// A stalled result holds the walk in place; a new request is taken once the last result
// of the previous one has been loaded, the result register is free and cfg is not valid.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_ring_lifo (
  input  wire logic clk,
  input  wire logic rst,
  orl_req_if.sink   req,
  orl_res_if.source res,
  orl_cfg_if.sink   cfg
);

  orl_pkg::cmd_t  cmd;
  orl_pkg::stat_t st;
  logic           res_valid;

  orl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .res_valid (res_valid),
    .res_ready (res.ready),
    .st        (st),
    .cmd       (cmd)
  );

  orl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .record_in    (req.record_in),
    .amount       (req.amount),
    .cap_wdata    (cfg.capacity_in_use),
    .st           (st),
    .record_out   (res.record_out),
    .record_valid (res.record_valid),
    .status       (res.status),
    .stored_count (res.stored_count),
    .last_of_run  (res.last_of_run)
  );

  assign res.valid = res_valid;

endmodule

`default_nettype wire
